// ===== rtl/rebp_pkg.sv =====
// shared constants, types and helpers for the rotary encoder and button poller
package rebp_pkg;

    localparam int COUNT_BITS = 8;
    localparam int CNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int EVENT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ENC_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 1'd1;

    localparam logic [CFG_W-1:0] ENC_LIMIT_RESET  = 8'd3;
    localparam logic [CFG_W-1:0] HOLD_LIMIT_RESET = 8'd255;

    localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CW    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_CCW   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_KNOB  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_GREEN = 3'd4;
    localparam logic [EVENT_W-1:0] EV_BLUE  = 3'd5;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [EVENT_W-1:0]    event_t;

    typedef struct packed {
        logic fire;
        logic ccw;
    } step_t;

    function automatic count_t clamp_count(input logic [CFG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(CNT_MAX))
        begin
            w = 32'(CNT_MAX);
        end
        return w[COUNT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/rebp_if.sv =====
// valid/ready channel interfaces for pin samples and event results
interface rebp_in_if;
    logic valid;
    logic ready;
    logic chan_a;
    logic chan_b;
    logic knob_switch;
    logic green_key;
    logic blue_key;

    modport source (output valid, output chan_a, output chan_b, output knob_switch,
                    output green_key, output blue_key, input ready);
    modport sink (input valid, input chan_a, input chan_b, input knob_switch,
                  input green_key, input blue_key, output ready);
endinterface

interface rebp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink (input valid, input event_code, output ready);
endinterface

// ===== rtl/rotary_encoder_button_poller_top.sv =====
// Rotary encoder and button poller: one pin sample transaction in, one event code out.
// Each accepted sample gives exactly one result, registered in the next cycle; a new sample is taken
// every cycle while the output register is empty or being drained, so throughput is one
// transaction per cycle, set by the combinational counter update into the result register.
// Event codes: 0 none, 1 cw, 2 ccw, 3 knob switch, 4 green, 5 blue; when several occur in
// one sample the higher code wins. Write limits via cfg port only while idle; unenforced.
module rotary_encoder_button_poller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    rebp_in_if.sink                        in_ch,
    rebp_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [rebp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rebp_pkg::CFG_W-1:0]     cfg_data
);
    import rebp_pkg::*;

    logic [CFG_W-1:0] enc_limit_reg;
    logic [CFG_W-1:0] hold_limit_reg;
    logic             out_valid_reg;
    event_t           event_reg;
    event_t           event_next;
    count_t           low_lim;
    count_t           hold;
    logic             accept;
    step_t            step;
    logic             knob_emit;
    logic             green_emit;
    logic             blue_emit;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign low_lim     = clamp_count(enc_limit_reg);
    assign hold        = (clamp_count(hold_limit_reg) == '0) ? count_t'(1)
                                                             : clamp_count(hold_limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_limit_reg  <= ENC_LIMIT_RESET;
            hold_limit_reg <= HOLD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENC_LIMIT:  enc_limit_reg  <= cfg_data;
                REG_HOLD_LIMIT: hold_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rebp_encoder u_encoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .chan_a  (in_ch.chan_a),
        .chan_b  (in_ch.chan_b),
        .low_lim (low_lim),
        .step    (step)
    );

    rebp_button u_knob (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .level  (in_ch.knob_switch),
        .hold   (hold),
        .emit   (knob_emit)
    );

    rebp_button u_green (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .level  (in_ch.green_key),
        .hold   (hold),
        .emit   (green_emit)
    );

    rebp_button u_blue (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .level  (in_ch.blue_key),
        .hold   (hold),
        .emit   (blue_emit)
    );

    always_comb
    begin
        event_next = EV_NONE;
        if (step.fire)
        begin
            event_next = step.ccw ? EV_CCW : EV_CW;
        end
        if (knob_emit)
        begin
            event_next = EV_KNOB;
        end
        if (green_emit)
        begin
            event_next = EV_GREEN;
        end
        if (blue_emit)
        begin
            event_next = EV_BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= event_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.event_code = event_reg;

    a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> event_reg <= EV_BLUE)
        else $error("event code out of range");
    a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");
    a_blue_wins: assert property (@(posedge clk) disable iff (!rst_n)
        accept && blue_emit |=> event_reg == EV_BLUE)
        else $error("blue release lost priority");

endmodule

// ===== rtl/rebp_encoder.sv =====
// encoder step detector: low-time counter on channel A, direction from channel B
module rebp_encoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              chan_a,
    input  logic              chan_b,
    input  rebp_pkg::count_t  low_lim,
    output rebp_pkg::step_t   step
);
    import rebp_pkg::*;

    count_t cnt_reg;
    count_t cnt_next;
    logic   trig_reg;
    logic   trig_next;
    logic   rep_reg;
    logic   rep_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        trig_next = trig_reg;
        rep_next  = rep_reg;
        step.fire = 1'b0;
        step.ccw  = 1'b0;
        if (!chan_a && !trig_reg)
        begin
            if (cnt_reg < low_lim)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                trig_next = 1'b1;
                cnt_next  = '0;
            end
        end
        if (trig_next && !rep_reg)
        begin
            step.fire = 1'b1;
            step.ccw  = !chan_b;
            rep_next  = 1'b1;
        end
        if (rep_next && chan_a)
        begin
            rep_next  = 1'b0;
            trig_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            trig_reg <= 1'b0;
            rep_reg  <= 1'b0;
        end
        else if (accept)
        begin
            cnt_reg  <= cnt_next;
            trig_reg <= trig_next;
            rep_reg  <= rep_next;
        end
    end

    // trigger and report always move together between transactions
    a_trig_rep: assert property (@(posedge clk) disable iff (!rst_n) trig_reg == rep_reg)
        else $error("step trigger and report flags disagree");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n) trig_reg |-> cnt_reg == '0)
        else $error("low counter not cleared while triggered");

endmodule

// ===== rtl/rebp_button.sv =====
// saturating press counter for one button, emits on release at the hold value
module rebp_button (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             level,
    input  rebp_pkg::count_t hold,
    output logic             emit
);
    import rebp_pkg::*;

    count_t cnt_reg;
    count_t cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        emit     = 1'b0;
        if (!level)
        begin
            if (cnt_reg < hold)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (cnt_reg == hold)
        begin
            cnt_next = '0;
            emit     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== verif/rotary_encoder_button_poller_top_test.sv =====
// self-checking testbench for the rotary encoder and button poller top level
`timescale 1ns / 100ps

module rotary_encoder_button_poller_top_test;
    import rebp_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rebp_in_if  in_ch ();
    rebp_out_if out_ch ();

    rotary_encoder_button_poller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of limits and encoder/button state
    logic [CFG_W-1:0] enc_low_limit;
    logic [CFG_W-1:0] btn_hold_limit;
    count_t           a_low_ticks;
    logic             step_fired;
    logic             step_sent;
    count_t           knob_presses;
    count_t           green_presses;
    count_t           blue_presses;

    event_t expected_events [$];
    int     mismatch_count;
    int     src_idle_pct;
    int     snk_idle_pct;
    int     stall_cycles;

    function automatic logic button_released(inout count_t presses, input logic level,
                                             input count_t hold);
        if (!level)
        begin
            if (presses < hold)
                presses = presses + 1'b1;
            return 1'b0;
        end
        if (presses == hold)
        begin
            presses = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic event_t predict_event(input logic a, input logic b, input logic knob,
                                             input logic green, input logic blue);
        event_t ev;
        count_t hold;
        ev = EV_NONE;
        // a zero hold limit behaves as one
        hold = (btn_hold_limit == '0) ? count_t'(1) : count_t'(btn_hold_limit);
        if (!a && !step_fired)
        begin
            if (a_low_ticks < count_t'(enc_low_limit))
                a_low_ticks = a_low_ticks + 1'b1;
            else
            begin
                step_fired  = 1'b1;
                a_low_ticks = '0;
            end
        end
        if (step_fired && !step_sent)
        begin
            ev        = b ? EV_CW : EV_CCW;
            step_sent = 1'b1;
        end
        if (step_sent && a)
        begin
            step_sent  = 1'b0;
            step_fired = 1'b0;
        end
        // later release wins
        if (button_released(knob_presses, knob, hold))
            ev = EV_KNOB;
        if (button_released(green_presses, green, hold))
            ev = EV_GREEN;
        if (button_released(blue_presses, blue, hold))
            ev = EV_BLUE;
        return ev;
    endfunction

    task automatic send_sample(input logic a, input logic b, input logic knob,
                               input logic green, input logic blue);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.chan_a      <= a;
        in_ch.chan_b      <= b;
        in_ch.knob_switch <= knob;
        in_ch.green_key   <= green;
        in_ch.blue_key    <= blue;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        expected_events.push_back(predict_event(a, b, knob, green, blue));
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_events.size() != 0);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] enc, input logic [CFG_W-1:0] hold);
        wait_results_drained();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENC_LIMIT;
        cfg_data  <= enc;
        @(posedge clk);
        enc_low_limit = enc;
        cfg_index <= REG_HOLD_LIMIT;
        cfg_data  <= hold;
        @(posedge clk);
        btn_hold_limit = hold;
        cfg_we <= 1'b0;
    endtask

    task automatic test_default_limits();
        // reset limits: step fires after four low samples of a
        send_sample(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_event_priority();
        set_limits(8'd0, 8'd1);
        send_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // zero hold limit
        set_limits(8'd0, 8'd0);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_early_release();
        set_limits(8'd1, 8'd3);
        send_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_limit_extremes();
        set_limits(8'd255, 8'd255);
        // green held the full limit, blue saturates, a long enough to trigger
        for (int i = 0; i < 262; i++)
            send_sample(i >= 258, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        !(i >= 1 && i < 256), 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] enc,
                                       input logic [CFG_W-1:0] hold, input int n_items);
        logic [4:0] lvl;
        int         run_left [5];
        int         hold_eff;
        int         len;
        set_limits(enc, hold);
        hold_eff = (hold == '0) ? 1 : int'(hold);
        lvl = '0;
        for (int p = 0; p < 5; p++)
            run_left[p] = 0;
        for (int i = 0; i < n_items; i++)
        begin
            for (int p = 0; p < 5; p++)
            begin
                if (run_left[p] == 0)
                begin
                    lvl[p] = ~lvl[p];
                    if ($urandom_range(7) == 0)
                        len = 1;
                    else if (lvl[p])
                        len = int'($urandom_range(1, 5));
                    else if (p == 0)
                        len = int'(enc) + int'($urandom_range(0, 2));
                    else
                        len = hold_eff - 1 + int'($urandom_range(0, 2));
                    run_left[p] = (len < 1) ? 1 : len;
                end
                run_left[p]--;
            end
            lvl[1] = 1'($urandom_range(1));
            send_sample(lvl[0], lvl[1], lvl[2], lvl[3], lvl[4]);
            if (i % 60 == 59)
                wait_results_drained();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: event %0d", out_ch.event_code);
            end
            else if (out_ch.event_code !== expected_events[0])
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: event expected %0d, actual %0d",
                             expected_events[0], out_ch.event_code);
                void'(expected_events.pop_front());
            end
            else
                void'(expected_events.pop_front());
        end
    end

    // watchdog
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        enc_low_limit  = ENC_LIMIT_RESET;
        btn_hold_limit = HOLD_LIMIT_RESET;
        a_low_ticks    = '0;
        step_fired     = 1'b0;
        step_sent      = 1'b0;
        knob_presses   = '0;
        green_presses  = '0;
        blue_presses   = '0;
        src_idle_pct   = 14;
        snk_idle_pct   = 45;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_ENC_LIMIT;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.chan_a      <= 1'b1;
        in_ch.chan_b      <= 1'b1;
        in_ch.knob_switch <= 1'b1;
        in_ch.green_key   <= 1'b1;
        in_ch.blue_key    <= 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_default_limits();
        test_event_priority();
        test_early_release();
        test_limit_extremes();
        test_random_traffic(8'd2, 8'd4, 125);

        src_idle_pct = 45;
        snk_idle_pct = 14;
        test_random_traffic(8'($urandom_range(0, 5)), 8'($urandom_range(1, 8)), 125);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(8'd1, 8'd2, 125);

        wait_results_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
